/* rtl/core/pur_pkg.sv */
// Shared types and constants for the particle update pipeline.
// No dependencies; used by the square root, divider and top level.
`default_nettype none

package pur_pkg;

  // Fractional bits of positions and velocities
  localparam int FRAC_BITS = 8;

  // Square root: 40-bit radicand, one root bit per stage
  localparam int SQ_IN_W   = 40;
  localparam int ROOT_W    = SQ_IN_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 2;

  // Divider: |d| << FRAC_BITS over the root, quotient at most one pixel
  localparam int MAG_W     = 21;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NUM_W     = MAG_W + FRAC_BITS;

  localparam int VD_W      = 18;  // damped velocity, exact

  // Configuration register indexes
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_GRAVITY_STEP = 3'd2;
  localparam logic [2:0] CFG_DAMPING      = 3'd3;
  localparam logic [2:0] CFG_REPEL_RADIUS = 3'd4;

  // Per-item data carried alongside the root and divide stages
  typedef struct packed {
    logic [19:0]            pos_x;
    logic [19:0]            pos_y;
    logic signed [VD_W-1:0] vel_x;
    logic signed [VD_W-1:0] vel_y;
    logic                   neg_x;
    logic                   neg_y;
    logic [MAG_W-1:0]       mag_x;
    logic [MAG_W-1:0]       mag_y;
    logic                   hit;
  } side_t;

endpackage

`default_nettype wire

/* rtl/core/particle_update_with_repulsion_top.sv */
// Top level of the particle update with pointer repulsion.
// Depends on pur_pkg, pur_isqrt and pur_div.
//
// Usage:
//   s_tdata carries one particle item: position, velocity and pointer.
//   m_tdata returns the particle after one tick, one item per input item.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five registers
//   (frame width, frame height, gravity, damping, repel radius); write
//   them only while no item is in flight. cfg_ready is always high.
// Throughput: one item per cycle, sustained while m_tready is high.
// Pipeline: from input accept to output valid an item passes five stages of
//   gravity, move, damping and squared distance, twenty stages of square
//   root (one root bit each), nine stages of divide (one quotient bit
//   each) and the output register.
// Reset: clears all valid bits and loads the register reset values.
// Stall: when m_tready is low with a result held, the whole pipeline
//   holds and s_tready goes low; nothing is lost or repeated.
`default_nettype none

module particle_update_with_repulsion_top import pur_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pos_x[19:0], pos_y[39:20], vel_x[55:40], vel_y[71:56],
  // pointer_x[83:72], pointer_y[95:84]
  input  wire logic [95:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // new_pos_x[19:0], new_pos_y[39:20], new_vel_x[55:40], new_vel_y[71:56]
  output logic [71:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  logic        en;
  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [7:0]  gravity_step;
  logic [8:0]  damping_factor;
  logic [11:0] repel_radius;
  logic [39:0] rad_sq;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= 12'd640;
      frame_height   <= 12'd480;
      gravity_step   <= 8'd10;
      damping_factor <= 9'd251;
      repel_radius   <= 12'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width    <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height   <= cfg_data;
        CFG_GRAVITY_STEP: gravity_step   <= cfg_data[7:0];
        CFG_DAMPING:      damping_factor <= cfg_data[8:0];
        CFG_REPEL_RADIUS: repel_radius   <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared radius in fixed point, follows the register
  always_ff @(posedge clk) begin
    rad_sq <= {repel_radius, FRAC_BITS'(0)} * {repel_radius, FRAC_BITS'(0)};
  end

  function automatic logic [19:0] wrap_pos(input logic signed [21:0] p,
                                           input logic [11:0] size);
    logic signed [21:0] edge_v;
    logic [11:0]        sm1;
    edge_v = $signed({2'b00, size, FRAC_BITS'(0)});
    sm1    = size - 12'd1;
    if (p > edge_v) begin
      wrap_pos = 20'd1 << FRAC_BITS;
    end else if (p < 0) begin
      wrap_pos = (size != '0) ? {sm1, FRAC_BITS'(0)} : '0;
    end else begin
      wrap_pos = p[19:0];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  // ---------------- stage 1: gravity and move
  logic                s1_valid;
  logic signed [21:0]  s1_px, s1_py;
  logic signed [15:0]  s1_vx, s1_vy;
  logic [11:0]         s1_ptx, s1_pty;
  logic signed [16:0]  vy_sum;
  logic signed [15:0]  vy_g;
  logic signed [21:0]  px_sum, py_sum;

  always_comb begin
    vy_sum = $signed({s_tdata[71], s_tdata[71:56]}) + $signed({9'b0, gravity_step});
    vy_g   = sat16(19'(vy_sum));
    px_sum = $signed({2'b00, s_tdata[19:0]}) + 22'($signed(s_tdata[55:40]));
    py_sum = $signed({2'b00, s_tdata[39:20]}) + 22'(vy_g);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px  <= px_sum;
      s1_py  <= py_sum;
      s1_vx  <= s_tdata[55:40];
      s1_vy  <= vy_g;
      s1_ptx <= s_tdata[83:72];
      s1_pty <= s_tdata[95:84];
    end
  end

  // ---------------- stage 2: damping, distance, wrap
  logic                   s2_valid;
  logic signed [VD_W-1:0] s2_vx, s2_vy;
  logic signed [21:0]     s2_dx, s2_dy;
  logic [19:0]            s2_px, s2_py;
  logic signed [25:0]     mul_x, mul_y;

  always_comb begin
    mul_x = s1_vx * $signed({1'b0, damping_factor});
    mul_y = s1_vy * $signed({1'b0, damping_factor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vx <= mul_x[25:FRAC_BITS];
      s2_vy <= mul_y[25:FRAC_BITS];
      s2_dx <= $signed({2'b00, s1_ptx, FRAC_BITS'(0)}) - s1_px;
      s2_dy <= $signed({2'b00, s1_pty, FRAC_BITS'(0)}) - s1_py;
      s2_px <= wrap_pos(s1_px, frame_width);
      s2_py <= wrap_pos(s1_py, frame_height);
    end
  end

  // ---------------- stage 3: sign and magnitude of distance
  logic  s3_valid;
  side_t s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side.pos_x <= s2_px;
      s3_side.pos_y <= s2_py;
      s3_side.vel_x <= s2_vx;
      s3_side.vel_y <= s2_vy;
      s3_side.neg_x <= s2_dx[21];
      s3_side.neg_y <= s2_dy[21];
      s3_side.mag_x <= s2_dx[21] ? MAG_W'(-s2_dx) : s2_dx[MAG_W-1:0];
      s3_side.mag_y <= s2_dy[21] ? MAG_W'(-s2_dy) : s2_dy[MAG_W-1:0];
      s3_side.hit   <= 1'b0;
    end
  end

  // ---------------- stage 4: squares
  logic        s4_valid;
  side_t       s4_side;
  logic [41:0] s4_sqx, s4_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side <= s3_side;
      s4_sqx  <= s3_side.mag_x * s3_side.mag_x;
      s4_sqy  <= s3_side.mag_y * s3_side.mag_y;
    end
  end

  // ---------------- stage 5: sum and radius test
  logic        s5_valid;
  side_t       s5_side;
  side_t       s5_side_next;
  logic [39:0] s5_rad;
  logic [42:0] dist_sq;

  assign dist_sq = {1'b0, s4_sqx} + {1'b0, s4_sqy};

  always_comb begin
    s5_side_next     = s4_side;
    s5_side_next.hit = dist_sq < {3'b000, rad_sq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side <= s5_side_next;
      s5_rad  <= dist_sq[39:0];
    end
  end

  // ---------------- square root and divide
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;
  logic              dv_valid;
  logic [QUO_W-1:0]  dv_qx, dv_qy;
  side_t             dv_side;

  pur_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .in_rad    (s5_rad),
    .in_side   (s5_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  pur_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy),
    .out_side  (dv_side)
  );

  // ---------------- output: apply repulsion, saturate
  logic signed [18:0] vx_f, vy_f;

  always_comb begin
    vx_f = dv_side.neg_x ? 19'(dv_side.vel_x) + $signed({10'b0, dv_qx})
                         : 19'(dv_side.vel_x) - $signed({10'b0, dv_qx});
    vy_f = dv_side.neg_y ? 19'(dv_side.vel_y) + $signed({10'b0, dv_qy})
                         : 19'(dv_side.vel_y) - $signed({10'b0, dv_qy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {sat16(vy_f), sat16(vx_f), dv_side.pos_y, dv_side.pos_x};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pur_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on pur_pkg; carries side_t data along with each item.
`default_nettype none

module pur_isqrt import pur_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [SQ_IN_W-1:0] in_rad,
  input  wire side_t              in_side,
  output logic                    out_valid,
  output logic [ROOT_W-1:0]       out_root,
  output side_t                   out_side
);

  logic [ROOT_W:0]     vld;
  logic [SQ_IN_W-1:0]  rad  [ROOT_W+1];
  logic [SQ_REM_W-1:0] rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   root [ROOT_W+1];
  side_t               side [ROOT_W+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [SQ_REM_W+1:0] cur;
    logic [SQ_REM_W+1:0] trial;
    logic                take;

    // bring down two radicand bits and try the next root bit
    always_comb begin
      cur   = {rem[i], rad[i][SQ_IN_W-1 -: 2]};
      trial = {2'b00, root[i], 2'b01};
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1]  <= {rad[i][SQ_IN_W-3:0], 2'b00};
        rem[i+1]  <= take ? SQ_REM_W'(cur - trial) : cur[SQ_REM_W-1:0];
        root[i+1] <= {root[i][ROOT_W-2:0], take};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

`default_nettype wire

/* rtl/core/pur_div.sv */
// Pipelined restoring divider for the repulsion unit vector, two lanes.
// Depends on pur_pkg; quotient magnitudes are zero when repulsion is off.
`default_nettype none

module pur_div import pur_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [ROOT_W-1:0] in_root,
  input  wire side_t             in_side,
  output logic                   out_valid,
  output logic [QUO_W-1:0]       out_qx,
  output logic [QUO_W-1:0]       out_qy,
  output side_t                  out_side
);

  logic [QUO_W:0]     vld;
  logic               app  [QUO_W+1];
  logic [ROOT_W-1:0]  dvs  [QUO_W+1];
  logic [NUM_W-1:0]   nx   [QUO_W+1];
  logic [NUM_W-1:0]   ny   [QUO_W+1];
  logic [QUO_W-1:0]   qx   [QUO_W+1];
  logic [QUO_W-1:0]   qy   [QUO_W+1];
  side_t              side [QUO_W+1];

  assign vld[0]  = in_valid;
  assign app[0]  = in_side.hit && (in_root != '0);
  assign dvs[0]  = in_root;
  assign nx[0]   = {in_side.mag_x, FRAC_BITS'(0)};
  assign ny[0]   = {in_side.mag_y, FRAC_BITS'(0)};
  assign qx[0]   = '0;
  assign qy[0]   = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [NUM_W-1:0] dsh;
    logic             bx;
    logic             by;

    // compare against the divisor aligned to this quotient bit
    always_comb begin
      dsh = NUM_W'(dvs[i]) << (QUO_W - 1 - i);
      bx  = (nx[i] >= dsh);
      by  = (ny[i] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        app[i+1]  <= app[i];
        dvs[i+1]  <= dvs[i];
        nx[i+1]   <= bx ? nx[i] - dsh : nx[i];
        ny[i+1]   <= by ? ny[i] - dsh : ny[i];
        qx[i+1]   <= {qx[i][QUO_W-2:0], bx};
        qy[i+1]   <= {qy[i][QUO_W-2:0], by};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_qx    = app[QUO_W] ? qx[QUO_W] : '0;
  assign out_qy    = app[QUO_W] ? qy[QUO_W] : '0;
  assign out_side  = side[QUO_W];

endmodule

`default_nettype wire
